// ===== src/dnm_pkg.sv =====
`default_nettype none
package dnm_pkg;

  // sizes
  localparam int NUMBER_BUFFER = 8;
  localparam int SLOT_COUNT    = 13;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int DIGIT_W       = $clog2(NUMBER_BUFFER);
  localparam logic [DIGIT_W-1:0] MAX_DIGITS = DIGIT_W'(NUMBER_BUFFER - 1);

  // operations
  localparam logic OP_TEXT   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // accumulator value meaning too large
  localparam logic [7:0] ACC_SAT = 8'd128;

  // line phases
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_COMMENT,
    PH_CODE,
    PH_BLANK1,
    PH_NOTE,
    PH_BLANK2,
    PH_VEL,
    PH_TAIL
  } phase_t;

  // slot codes, first letter in the upper byte
  localparam logic [15:0] SLOT_CODES [SLOT_COUNT] = '{
    16'h4348, 16'h4f48, 16'h4359, 16'h4342, 16'h4350, 16'h5253, 16'h4854,
    16'h4d54, 16'h4c54, 16'h5344, 16'h4244, 16'h4143, 16'h4748
  };
  localparam logic [6:0] RESET_NOTES [SLOT_COUNT] = '{
    7'd42, 7'd46, 7'd49, 7'd56, 7'd39, 7'd37, 7'd50, 7'd47, 7'd41, 7'd38,
    7'd36, 7'd31, 7'd38
  };
  localparam logic [6:0] VEL_DEFAULT = 7'd100;
  localparam logic [6:0] VEL_LAST    = 7'd40;

  // completed line handed to the slot table
  typedef struct packed {
    logic       eval;
    logic [7:0] first;
    logic [7:0] second;
    logic [6:0] note;
    logic [6:0] vel;
  } line_eval_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } slot_match_t;

  typedef struct packed {
    logic              update_valid;
    logic [SLOT_W-1:0] updated_slot;
    logic [6:0]        updated_note;
    logic [6:0]        updated_velocity;
    logic              text_done;
    logic              text_changed;
    logic              lookup_found;
    logic [6:0]        lookup_note;
    logic [6:0]        lookup_velocity;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) ? (c - 8'd32) : c;
  endfunction

  // times ten plus digit, saturating at 128
  function automatic logic [7:0] sat_digit(input logic [7:0] acc, input logic [7:0] c);
    logic [10:0] t;
    t = (11'(acc) << 3) + (11'(acc) << 1) + 11'(c[3:0]);
    if (acc[7]) return ACC_SAT;
    else if (t > 11'd127) return ACC_SAT;
    else return t[7:0];
  endfunction

  // parallel compare against all slot codes
  function automatic slot_match_t find_slot(input logic [7:0] a, input logic [7:0] b);
    slot_match_t m;
    m = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (SLOT_CODES[k] == {a, b}) begin
        m.hit = 1'b1;
        m.idx = SLOT_W'(k);
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== src/dnm_if.sv =====
`default_nettype none
interface dnm_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] text_char;
  logic       final_char;
  logic [7:0] query_first;
  logic [7:0] query_second;

  modport source (output valid, operation, text_char, final_char, query_first,
                  query_second, input ready);
  modport sink (input valid, operation, text_char, final_char, query_first,
                query_second, output ready);
endinterface

interface dnm_out_if;
  logic       valid;
  logic       ready;
  logic       update_valid;
  logic [3:0] updated_slot;
  logic [6:0] updated_note;
  logic [6:0] updated_velocity;
  logic       text_done;
  logic       text_changed;
  logic       lookup_found;
  logic [6:0] lookup_note;
  logic [6:0] lookup_velocity;

  modport source (output valid, update_valid, updated_slot, updated_note,
                  updated_velocity, text_done, text_changed, lookup_found,
                  lookup_note, lookup_velocity, input ready);
  modport sink (input valid, update_valid, updated_slot, updated_note,
                updated_velocity, text_done, text_changed, lookup_found,
                lookup_note, lookup_velocity, output ready);
endinterface
`default_nettype wire

// ===== src/dnm_line_parser.sv =====
`default_nettype none
module dnm_line_parser
  import dnm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] text_char,
  input  wire logic       final_char,
  output line_eval_t      ev
);

  phase_t             phase, phase_next;
  logic [7:0]         first, first_next;
  logic [7:0]         second, second_next;
  logic [1:0]         code_count, code_count_next;
  logic [7:0]         note_acc, note_acc_next;
  logic [DIGIT_W-1:0] note_cnt, note_cnt_next;
  logic [7:0]         vel_acc, vel_acc_next;
  logic [DIGIT_W-1:0] vel_cnt, vel_cnt_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      first      <= '0;
      second     <= '0;
      code_count <= '0;
      note_acc   <= '0;
      note_cnt   <= '0;
      vel_acc    <= '0;
      vel_cnt    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      first      <= first_next;
      second     <= second_next;
      code_count <= code_count_next;
      note_acc   <= note_acc_next;
      note_cnt   <= note_cnt_next;
      vel_acc    <= vel_acc_next;
      vel_cnt    <= vel_cnt_next;
    end
  end

  // one character walks through the phases until something consumes it
  always_comb begin
    logic used;
    logic vel_eval;
    used            = 1'b0;
    vel_eval        = 1'b0;
    phase_next      = phase;
    first_next      = first;
    second_next     = second;
    code_count_next = code_count;
    note_acc_next   = note_acc;
    note_cnt_next   = note_cnt;
    vel_acc_next    = vel_acc;
    vel_cnt_next    = vel_cnt;

    // line start and comment lines
    case (phase)
      PH_LEAD: begin
        if (is_blank(text_char) || text_char == CH_LF) begin
          phase_next = PH_LEAD;
        end else if (text_char == CH_CR || text_char == CH_HASH) begin
          phase_next = PH_COMMENT;
        end else begin
          first_next      = '0;
          second_next     = '0;
          code_count_next = '0;
          note_acc_next   = '0;
          note_cnt_next   = '0;
          vel_acc_next    = '0;
          vel_cnt_next    = '0;
          phase_next      = PH_CODE;
        end
      end
      PH_COMMENT: begin
        if (text_char == CH_LF) phase_next = PH_LEAD;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // code letters
    if (phase_next == PH_CODE) begin
      if (code_count_next < 2'd2 && is_alpha(text_char)) begin
        first_next      = second_next;
        second_next     = fold_upper(text_char);
        code_count_next = code_count_next + 2'd1;
        used            = 1'b1;
      end else begin
        phase_next = PH_BLANK1;
      end
    end
    if (phase_next == PH_BLANK1 && !used) begin
      if (is_blank(text_char)) used = 1'b1;
      else phase_next = PH_NOTE;
    end

    // note digits
    if (phase_next == PH_NOTE && !used) begin
      if (is_digit(text_char) && note_cnt_next < MAX_DIGITS) begin
        note_acc_next = sat_digit(note_acc_next, text_char);
        note_cnt_next = note_cnt_next + DIGIT_W'(1);
        used          = 1'b1;
      end else begin
        phase_next = PH_BLANK2;
      end
    end
    if (phase_next == PH_BLANK2 && !used) begin
      if (is_blank(text_char)) used = 1'b1;
      else phase_next = PH_VEL;
    end

    // velocity digits, anything else closes the line
    if (phase_next == PH_VEL && !used) begin
      if (is_digit(text_char) && vel_cnt_next < MAX_DIGITS) begin
        vel_acc_next = sat_digit(vel_acc_next, text_char);
        vel_cnt_next = vel_cnt_next + DIGIT_W'(1);
        used         = 1'b1;
      end else begin
        vel_eval   = 1'b1;
        phase_next = PH_TAIL;
      end
    end
    if (phase_next == PH_TAIL && !used) begin
      if (text_char == CH_LF) phase_next = PH_LEAD;
    end

    // line check, slot match is done in the table
    ev.first  = first_next;
    ev.second = second_next;
    ev.note   = note_acc_next[6:0];
    ev.vel    = vel_acc_next[6:0];
    ev.eval   = (vel_eval ||
                 (final_char && phase_next != PH_LEAD && phase_next != PH_COMMENT &&
                  phase_next != PH_TAIL)) &&
                code_count_next == 2'd2 && !note_acc_next[7] &&
                vel_acc_next != 8'd0 && !vel_acc_next[7];

    // end of text resets the parser
    if (final_char) begin
      phase_next      = PH_LEAD;
      first_next      = '0;
      second_next     = '0;
      code_count_next = '0;
      note_acc_next   = '0;
      note_cnt_next   = '0;
      vel_acc_next    = '0;
      vel_cnt_next    = '0;
    end
  end

endmodule
`default_nettype wire

// ===== src/dnm_slot_table.sv =====
`default_nettype none
module dnm_slot_table
  import dnm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step_text,
  input  wire logic       step_lookup,
  input  wire logic       final_char,
  input  wire logic [7:0] query_first,
  input  wire logic [7:0] query_second,
  input  wire line_eval_t ev,
  output result_t         res,
  output logic            emit
);

  logic [6:0]  notes [SLOT_COUNT];
  logic [6:0]  vels  [SLOT_COUNT];
  logic        changed;
  slot_match_t upd_m;
  slot_match_t look_m;
  logic        upd;

  // slot match for the closed line and for the lookup
  always_comb begin
    upd_m  = find_slot(ev.first, ev.second);
    look_m = find_slot(fold_upper(query_first), fold_upper(query_second));
    upd    = step_text && ev.eval && upd_m.hit;
  end

  // result fields
  always_comb begin
    res = '0;
    if (step_lookup) begin
      if (look_m.hit) begin
        res.lookup_found    = 1'b1;
        res.lookup_note     = notes[look_m.idx];
        res.lookup_velocity = vels[look_m.idx];
      end
    end else begin
      if (upd) begin
        res.update_valid     = 1'b1;
        res.updated_slot     = upd_m.idx;
        res.updated_note     = ev.note;
        res.updated_velocity = ev.vel;
      end
      if (final_char) begin
        res.text_done    = 1'b1;
        res.text_changed = changed || upd;
      end
    end
    emit = step_lookup || upd || (step_text && final_char);
  end

  // slot storage and change flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        notes[k] <= RESET_NOTES[k];
        vels[k]  <= (k == SLOT_COUNT - 1) ? VEL_LAST : VEL_DEFAULT;
      end
      changed <= 1'b0;
    end else begin
      if (upd) begin
        notes[upd_m.idx] <= ev.note;
        vels[upd_m.idx]  <= ev.vel;
      end
      if (step_text && final_char) changed <= 1'b0;
      else if (upd) changed <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/drum_note_map_text_parser.sv =====
// Drum note map text parser.
// item channel (dnm_in_if): one transaction per text character
// (operation = text) or per two-letter lookup (operation = lookup).
// result channel (dnm_out_if): at most one transaction per item: a
// text character yields one when it completes a line that rewrites a
// slot or when it is the final character; a lookup always yields one.
// Path: an accepted item is held in the input register, then parsed and
// compared with the slots, and its result goes into the result register
// when the result channel is not stalled.
// Throughput: one item per cycle while the result channel does not stall;
// the state of the parser and the slot table is updated as the item leaves the input
// register, so consecutive characters chain without a bubble.
// Reset: the parser returns to line start, the change flag clears and
// all 13 slots take their default note and velocity; both channel
// valids drop.
// Stall: while a result waits on result.ready, the item in the input
// register holds and item.ready stays high only if that register is
// empty, so at most one more item is taken and nothing is dropped.
`default_nettype none
module drum_note_map_text_parser
  import dnm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  dnm_in_if.sink   item,
  dnm_out_if.source result
);

  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_char;
  logic       s1_final;
  logic [7:0] s1_qa;
  logic [7:0] s1_qb;
  logic       out_valid;
  result_t    out_data;
  logic       out_full;
  logic       advance;
  line_eval_t ev;
  result_t    res;
  logic       emit;

  // handshake control
  assign out_full   = out_valid && !result.ready;
  assign advance    = s1_valid && !out_full;
  assign item.ready = !s1_valid || !out_full;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op    <= item.operation;
      s1_char  <= item.text_char;
      s1_final <= item.final_char;
      s1_qa    <= item.query_first;
      s1_qb    <= item.query_second;
    end
  end

  dnm_line_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance && s1_op == OP_TEXT),
    .text_char  (s1_char),
    .final_char (s1_final),
    .ev         (ev)
  );

  dnm_slot_table u_table (
    .clk          (clk),
    .rst          (rst),
    .step_text    (advance && s1_op == OP_TEXT),
    .step_lookup  (advance && s1_op == OP_LOOKUP),
    .final_char   (s1_final),
    .query_first  (s1_qa),
    .query_second (s1_qb),
    .ev           (ev),
    .res          (res),
    .emit         (emit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) out_data <= res;
  end

  assign result.valid            = out_valid;
  assign result.update_valid     = out_data.update_valid;
  assign result.updated_slot     = out_data.updated_slot;
  assign result.updated_note     = out_data.updated_note;
  assign result.updated_velocity = out_data.updated_velocity;
  assign result.text_done        = out_data.text_done;
  assign result.text_changed     = out_data.text_changed;
  assign result.lookup_found     = out_data.lookup_found;
  assign result.lookup_note      = out_data.lookup_note;
  assign result.lookup_velocity  = out_data.lookup_velocity;

endmodule
`default_nettype wire
